@@ rtl/core/image_stripe_partitioner_assert.svh @@
// ---------------------------------------------------------------------------
// Image stripe partitioner assertion macros
// Shared property shorthands, sampled on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef IMAGE_STRIPE_PARTITIONER_ASSERT_SVH
`define IMAGE_STRIPE_PARTITIONER_ASSERT_SVH

// same-cycle implication
`define ISP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ISP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/isp_pkg.sv @@
// ---------------------------------------------------------------------------
// Image stripe partitioner package
// Widths, limits, register indexes and the structs passed between modules.
// ---------------------------------------------------------------------------
package isp_pkg;

  localparam int DIM_W       = 16;
  localparam int BUDGET_W    = 13;
  localparam int THR_W       = 4;
  localparam int TIDX_W      = 3;
  localparam int CNT_W       = 7;
  localparam int DIV_W       = 32;
  localparam int MIB_SHIFT   = 18;
  localparam int MAX_THREADS = 8;
  localparam int MAX_CHUNKS  = 64;
  localparam int QUEUE_DEPTH = 2;

  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = BUDGET_W;

  localparam logic [CFG_IDX_W-1:0] CFG_BUDGET  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_THREADS = 1'b1;

  localparam logic [BUDGET_W-1:0] BUDGET_RST  = 13'd64;
  localparam logic [THR_W-1:0]    THREADS_RST = 4'd4;

  typedef struct packed {
    logic                oversize;
    logic [THR_W-1:0]    threads;
    logic [CNT_W-1:0]    group;
    logic [CNT_W-1:0]    total;
    logic [DIM_W-1:0]    base;
    logic [CNT_W-1:0]    rem;
  } plan_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DIV_W-1:0] remainder;
  } div_rsp_t;

endpackage

@@ rtl/core/image_stripe_partitioner.sv @@
// ---------------------------------------------------------------------------
// Image stripe partitioner
// Splits image rows into per-thread stripes under a memory budget.
// ---------------------------------------------------------------------------
// Input side is a queue: present width, height and format_ok with push while
// full is low. An invalid image (zero width, zero height or bad format) is
// dropped without any result. Results come out as a queue: while empty is low
// the ports hold the oldest stripe item; pop takes it. The last item of each
// image carries out_last; an image needing more than 64 chunks gives one
// item with out_oversize and out_last set.
// The front end takes one image at a time and works out its plan with up to
// four divisions on a shared radix-2 divider, then pushes the plan. Plans
// pass through a two-entry queue to the back end, which emits one stripe per
// cycle while the receiver pops, so up to 64 stripes overlap the next image.
// When the receiver stalls the back end holds its item, the plan queue fills
// and full stays high. Reset empties both queues and loads the registers
// with a 64 MiB budget and four threads. cfg_ready is always high; write the
// registers only while no image is in flight.
// ---------------------------------------------------------------------------
module image_stripe_partitioner (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [isp_pkg::DIM_W-1:0]        in_image_width,
  input  logic [isp_pkg::DIM_W-1:0]        in_image_height,
  input  logic                             in_format_ok,
  input  logic                             push,
  output logic                             full,
  output logic [isp_pkg::TIDX_W-1:0]       out_thread_index,
  output logic [isp_pkg::DIM_W-1:0]        out_first_row,
  output logic [isp_pkg::DIM_W-1:0]        out_row_count,
  output logic                             out_oversize,
  output logic                             out_last,
  output logic                             empty,
  input  logic                             pop,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [isp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [isp_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [isp_pkg::BUDGET_W-1:0] budget_r;
  logic [isp_pkg::THR_W-1:0]    threads_r;
  logic                         plan_push;
  logic                         plan_full;
  logic                         plan_valid;
  logic                         plan_pop;
  isp_pkg::plan_t               plan_in;
  isp_pkg::plan_t               plan_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r  <= isp_pkg::BUDGET_RST;
      threads_r <= isp_pkg::THREADS_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == isp_pkg::CFG_BUDGET) begin
        budget_r <= cfg_data[isp_pkg::BUDGET_W-1:0];
      end else if (cfg_index == isp_pkg::CFG_THREADS) begin
        threads_r <= cfg_data[isp_pkg::THR_W-1:0];
      end
    end
  end

  isp_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_image_width  (in_image_width),
    .in_image_height (in_image_height),
    .in_format_ok    (in_format_ok),
    .push            (push),
    .full            (full),
    .budget_mib      (budget_r),
    .threads         (threads_r),
    .plan_push       (plan_push),
    .plan            (plan_in),
    .plan_full       (plan_full)
  );

  isp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (plan_push),
    .wr_data (plan_in),
    .q_full  (plan_full),
    .q_valid (plan_valid),
    .rd_en   (plan_pop),
    .rd_data (plan_out)
  );

  isp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (plan_valid),
    .q_data           (plan_out),
    .q_pop            (plan_pop),
    .out_thread_index (out_thread_index),
    .out_first_row    (out_first_row),
    .out_row_count    (out_row_count),
    .out_oversize     (out_oversize),
    .out_last         (out_last),
    .empty            (empty),
    .pop              (pop)
  );

endmodule

@@ rtl/core/isp_div.sv @@
// ---------------------------------------------------------------------------
// Image stripe partitioner divider
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module isp_div (
  input  logic              clk,
  input  logic              rst_n,
  input  isp_pkg::div_req_t req,
  output isp_pkg::div_rsp_t rsp
);

  localparam int DW = isp_pkg::DIV_W;
  localparam int CW = $clog2(DW);

  logic [DW-1:0] rem_r;
  logic [DW-1:0] quo_r;
  logic [DW-1:0] dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   shl;
  logic [DW:0]   dif;
  logic          ge;
  logic          load;

  assign load = req.start && !busy_r;
  assign shl  = {rem_r, quo_r[DW-1]};
  assign dif  = shl - {1'b0, dvs_r};
  assign ge   = (shl >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (load) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= ge ? dif[DW-1:0] : shl[DW-1:0];
      quo_r <= {quo_r[DW-2:0], ge};
    end
  end

  assign rsp.busy      = busy_r;
  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

@@ rtl/core/isp_front.sv @@
// ---------------------------------------------------------------------------
// Image stripe partitioner front end
// Accepts an image, drops invalid ones and works out the stripe plan.
// ---------------------------------------------------------------------------
`include "image_stripe_partitioner_assert.svh"

module isp_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [isp_pkg::DIM_W-1:0]     in_image_width,
  input  logic [isp_pkg::DIM_W-1:0]     in_image_height,
  input  logic                          in_format_ok,
  input  logic                          push,
  output logic                          full,
  input  logic [isp_pkg::BUDGET_W-1:0]  budget_mib,
  input  logic [isp_pkg::THR_W-1:0]     threads,
  output logic                          plan_push,
  output isp_pkg::plan_t                plan,
  input  logic                          plan_full
);

  localparam int DW = isp_pkg::DIV_W;
  localparam int CW = isp_pkg::CNT_W;
  localparam int TW = isp_pkg::THR_W;
  localparam int HW = isp_pkg::DIM_W;
  localparam int BW = isp_pkg::BUDGET_W;
  localparam int PW = CW + TW + 1;

  typedef enum logic [6:0] {
    F_IDLE  = 7'b0000001,
    F_CHUNK = 7'b0000010,
    F_EST   = 7'b0000100,
    F_GROUP = 7'b0001000,
    F_TOTAL = 7'b0010000,
    F_ROWS  = 7'b0100000,
    F_PUSH  = 7'b1000000
  } fstate_t;

  fstate_t           state_r, state_nxt;
  logic              go_r, go_nxt;
  logic [HW-1:0]     w_r, h_r;
  logic [BW-1:0]     budget_r;
  logic [TW-1:0]     t_r;
  logic [DW-1:0]     prod_r;
  logic [DW-1:0]     chunk_r;
  logic [DW-1:0]     est_r;
  logic [CW-1:0]     group_r;
  logic              big_r;
  logic [CW-1:0]     total_r;
  logic              ovs_r;
  logic [HW-1:0]     base_r;
  logic [CW-1:0]     rem_r;
  logic              img_ok;
  logic [TW-1:0]     t_in;
  logic [PW-1:0]     tot_full;
  logic              tot_over;
  isp_pkg::div_req_t div_req;
  isp_pkg::div_rsp_t div_rsp;

  isp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign full   = (state_r != F_IDLE);
  assign img_ok = (in_image_width != '0) && (in_image_height != '0) && in_format_ok;

  always_comb begin
    if (threads == '0) begin
      t_in = TW'(1);
    end else if (threads > TW'(isp_pkg::MAX_THREADS)) begin
      t_in = TW'(isp_pkg::MAX_THREADS);
    end else begin
      t_in = threads;
    end
  end

  assign tot_full = PW'(group_r) * PW'({t_r, 1'b0});
  assign tot_over = big_r || (tot_full > PW'(isp_pkg::MAX_CHUNKS));

  always_comb begin
    state_nxt        = state_r;
    go_nxt           = go_r;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    plan_push        = 1'b0;
    unique case (state_r)
      F_IDLE: begin
        if (push && img_ok) begin
          state_nxt = F_CHUNK;
        end
      end
      F_CHUNK: begin
        div_req.start    = !go_r;
        div_req.dividend = DW'({budget_r, {isp_pkg::MIB_SHIFT{1'b0}}});
        div_req.divisor  = DW'(t_r);
        go_nxt           = 1'b1;
        if (div_rsp.done) begin
          go_nxt    = 1'b0;
          state_nxt = F_EST;
        end
      end
      F_EST: begin
        div_req.start    = !go_r;
        div_req.dividend = prod_r;
        div_req.divisor  = chunk_r;
        go_nxt           = 1'b1;
        if (div_rsp.done) begin
          go_nxt    = 1'b0;
          state_nxt = (div_rsp.quotient == '0) ? F_TOTAL : F_GROUP;
        end
      end
      F_GROUP: begin
        div_req.start    = !go_r;
        div_req.dividend = est_r - 1'b1;
        div_req.divisor  = DW'({t_r, 1'b0});
        go_nxt           = 1'b1;
        if (div_rsp.done) begin
          go_nxt    = 1'b0;
          state_nxt = F_TOTAL;
        end
      end
      F_TOTAL: begin
        state_nxt = tot_over ? F_PUSH : F_ROWS;
      end
      F_ROWS: begin
        div_req.start    = !go_r;
        div_req.dividend = DW'(h_r);
        div_req.divisor  = DW'(total_r);
        go_nxt           = 1'b1;
        if (div_rsp.done) begin
          go_nxt    = 1'b0;
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!plan_full) begin
          plan_push = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      go_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      go_r    <= go_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= DW'(w_r) * DW'(h_r);
    if (state_r == F_IDLE && push) begin
      w_r      <= in_image_width;
      h_r      <= in_image_height;
      budget_r <= (budget_mib == '0) ? BW'(1) : budget_mib;
      t_r      <= t_in;
      ovs_r    <= 1'b0;
      base_r   <= '0;
      rem_r    <= '0;
    end
    if (state_r == F_CHUNK && div_rsp.done) begin
      chunk_r <= div_rsp.quotient;
    end
    if (state_r == F_EST && div_rsp.done) begin
      est_r   <= div_rsp.quotient;
      group_r <= CW'(1);
      big_r   <= 1'b0;
    end
    if (state_r == F_GROUP && div_rsp.done) begin
      big_r   <= (div_rsp.quotient >= DW'(isp_pkg::MAX_CHUNKS));
      group_r <= div_rsp.quotient[CW-1:0] + 1'b1;
    end
    if (state_r == F_TOTAL) begin
      total_r <= tot_full[CW-1:0];
      ovs_r   <= tot_over;
    end
    if (state_r == F_ROWS && div_rsp.done) begin
      base_r <= div_rsp.quotient[HW-1:0];
      rem_r  <= div_rsp.remainder[CW-1:0];
    end
  end

  assign plan.oversize = ovs_r;
  assign plan.threads  = t_r;
  assign plan.group    = group_r;
  assign plan.total    = total_r;
  assign plan.base     = base_r;
  assign plan.rem      = rem_r;

  `ISP_ASSERT_IMPL(a_div_start_idle, div_req.start, !div_rsp.busy,
                   "divider started while busy")

endmodule

@@ rtl/core/isp_queue.sv @@
// ---------------------------------------------------------------------------
// Image stripe partitioner plan queue
// Short queue of stripe plans between the front and back ends.
// ---------------------------------------------------------------------------
`include "image_stripe_partitioner_assert.svh"

module isp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  isp_pkg::plan_t wr_data,
  output logic           q_full,
  output logic           q_valid,
  input  logic           rd_en,
  output isp_pkg::plan_t rd_data
);

  localparam int DEPTH = isp_pkg::QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = $clog2(DEPTH + 1);

  isp_pkg::plan_t mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r;
  logic [AW-1:0]  rd_ptr_r;
  logic [NW-1:0]  cnt_r;
  logic           do_wr;
  logic           do_rd;

  assign q_full  = (cnt_r == NW'(DEPTH));
  assign q_valid = (cnt_r != '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && q_valid;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  `ISP_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_r <= NW'(DEPTH),
                   "plan queue count out of range")

endmodule

@@ rtl/core/isp_back.sv @@
// ---------------------------------------------------------------------------
// Image stripe partitioner back end
// Walks a stripe plan and emits one stripe item per cycle into the output slot while it is empty or popped.
// ---------------------------------------------------------------------------
`include "image_stripe_partitioner_assert.svh"

module isp_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  isp_pkg::plan_t              q_data,
  output logic                        q_pop,
  output logic [isp_pkg::TIDX_W-1:0]  out_thread_index,
  output logic [isp_pkg::DIM_W-1:0]   out_first_row,
  output logic [isp_pkg::DIM_W-1:0]   out_row_count,
  output logic                        out_oversize,
  output logic                        out_last,
  output logic                        empty,
  input  logic                        pop
);

  localparam int CW = isp_pkg::CNT_W;
  localparam int TW = isp_pkg::THR_W;
  localparam int HW = isp_pkg::DIM_W;

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_RUN  = 2'b10
  } bstate_t;

  bstate_t        state_r;
  isp_pkg::plan_t plan_r;
  logic [CW-1:0]  acc_r, acc_nxt;
  logic [HW-1:0]  from_r;
  logic [CW-1:0]  n_r;
  logic [CW-1:0]  g_r;
  logic [TW-1:0]  i_r;
  logic           pass_r;
  logic           out_vld_r;
  logic           slot_free;
  logic           emit;
  logic [CW:0]    sum;
  logic [CW:0]    sum_wrap;
  logic           wrap;
  logic [HW-1:0]  rows;
  logic [TW-1:0]  thr;
  logic           last_stripe;
  logic           g_end;
  logic           i_end;

  assign slot_free   = !out_vld_r || pop;
  assign emit        = (state_r == B_RUN) && slot_free;
  assign q_pop       = (state_r == B_IDLE) && q_valid;
  assign empty       = !out_vld_r;

  assign sum         = {1'b0, acc_r} + {1'b0, plan_r.rem};
  assign sum_wrap    = sum - {1'b0, plan_r.total};
  assign wrap        = (sum >= {1'b0, plan_r.total});
  assign acc_nxt     = wrap ? sum_wrap[CW-1:0] : sum[CW-1:0];
  assign rows        = plan_r.base + HW'(wrap);
  assign thr         = pass_r ? (plan_r.threads - 1'b1 - i_r) : i_r;
  assign last_stripe = ((n_r + CW'(1)) == plan_r.total);
  assign g_end       = (g_r == plan_r.group - 1'b1);
  assign i_end       = (i_r == plan_r.threads - 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      if (emit) begin
        out_vld_r <= 1'b1;
      end else if (pop) begin
        out_vld_r <= 1'b0;
      end
      unique case (state_r)
        B_IDLE: begin
          if (q_valid) begin
            state_r <= B_RUN;
          end
        end
        B_RUN: begin
          if (emit && (plan_r.oversize || last_stripe)) begin
            state_r <= B_IDLE;
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      plan_r <= q_data;
      acc_r  <= '0;
      from_r <= '0;
      n_r    <= '0;
      g_r    <= '0;
      i_r    <= '0;
      pass_r <= 1'b0;
    end
    if (emit) begin
      if (plan_r.oversize) begin
        out_thread_index <= '0;
        out_first_row    <= '0;
        out_row_count    <= '0;
        out_oversize     <= 1'b1;
        out_last         <= 1'b1;
      end else begin
        out_thread_index <= thr[isp_pkg::TIDX_W-1:0];
        out_first_row    <= from_r;
        out_row_count    <= rows;
        out_oversize     <= 1'b0;
        out_last         <= last_stripe;
        acc_r            <= acc_nxt;
        from_r           <= from_r + rows;
        n_r              <= n_r + 1'b1;
        if (g_end) begin
          g_r <= '0;
          if (i_end) begin
            i_r    <= '0;
            pass_r <= 1'b1;
          end else begin
            i_r <= i_r + 1'b1;
          end
        end else begin
          g_r <= g_r + 1'b1;
        end
      end
    end
  end

  `ISP_ASSERT_IMPL(a_oversize_last, out_vld_r && out_oversize, out_last,
                   "oversize item without last mark")
  `ISP_ASSERT_IMPL(a_count_in_range, state_r == B_RUN && !plan_r.oversize,
                   n_r < plan_r.total, "stripe count ran past plan total")

endmodule
